@@ design/prf_pkg.sv @@
// Shared constants, types and helpers for the page replacement engine.
package prf_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 8;

  // Frame index and recency rank widths
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(FRAMES - 1);

  // Port field widths
  localparam int IN_PAGE_W  = 8;
  localparam int OUT_FRAME_W = 3;
  localparam int OUT_EVPG_W  = 8;
  localparam int FAULT_W     = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Policy codes
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                 clear;
    logic                 upd;
    logic [PAGE_BITS-1:0] page;
    logic                 old_valid;
    logic [RANK_W-1:0]    old_rank;
  } prf_bcast_t;

  // Contents of one cell
  typedef struct packed {
    logic                 valid;
    logic [RANK_W-1:0]    rank;
    logic [PAGE_BITS-1:0] page;
  } prf_cell_st_t;

  // One-hot to binary index
  function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [FRAMES-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (oh[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ design/page_replacement_fifo_lru.sv @@
// Sequencing: a request is captured into page_r on accept; the search and the cell update
//   happen in the LOOK state after the capture, stalling while a finished result is not taken.
// A new request is not taken until the search is finished; the search ripples through
//   the cell row and the cells update when the result is registered.
// Reset (rst_n low, synchronous): all frames empty, ranks, FIFO pointer, fault count
//   and policy cleared to zero; no pending result.
module page_replacement_fifo_lru
  import prf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic        cfg_wdata,    // policy
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] page
  input  logic        in_tuser,     // [0] restart
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata     // [0] hit, [3:1] frame, [4] evicted_valid,
                                    // [12:5] evicted_page, [28:13] fault_count, rest 0
);

  logic                 state_r, state_nxt;
  logic                 policy_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic                 out_valid_r;
  logic [31:0]          out_data_r;

  logic accept, done, clear;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign clear     = accept && in_tuser;
  assign done      = (state_r == ST_LOOK) && (!out_valid_r || out_tready);

  // Cell row
  prf_bcast_t          bc;
  logic [FRAMES-1:0]   sel_v, first_match_v, first_empty_v, lru_v;
  logic [FRAMES:0]     mseen, eseen;
  prf_cell_st_t        st_v [FRAMES];

  assign mseen[0] = 1'b0;
  assign eseen[0] = 1'b0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    prf_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .bc            (bc),
      .wr_sel        (sel_v[g]),
      .match_seen_i  (mseen[g]),
      .empty_seen_i  (eseen[g]),
      .match_seen_o  (mseen[g+1]),
      .empty_seen_o  (eseen[g+1]),
      .first_match_o (first_match_v[g]),
      .first_empty_o (first_empty_v[g]),
      .lru_o         (lru_v[g]),
      .st_o          (st_v[g])
    );
  end

  // Victim / hit frame selection
  logic                 hit_w, any_empty;
  logic [FRAMES-1:0]    ptr_dec;
  logic                 sel_valid;
  logic [RANK_W-1:0]    sel_rank;
  logic [PAGE_BITS-1:0] sel_page;
  logic [IDX_W-1:0]     sel_idx;

  assign hit_w     = mseen[FRAMES];
  assign any_empty = eseen[FRAMES];

  always_comb begin
    ptr_dec = '0;
    for (int i = 0; i < FRAMES; i++) begin
      ptr_dec[i] = (ptr_r == IDX_W'(i));
    end
    if (hit_w) begin
      sel_v = first_match_v;
    end else if (policy_r == POL_FIFO) begin
      sel_v = ptr_dec;
    end else if (any_empty) begin
      sel_v = first_empty_v;
    end else begin
      sel_v = lru_v;
    end
  end

  // Read out the selected cell
  always_comb begin
    sel_valid = 1'b0;
    sel_rank  = '0;
    sel_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel_v[i]) begin
        sel_valid = sel_valid | st_v[i].valid;
        sel_rank  = sel_rank  | st_v[i].rank;
        sel_page  = sel_page  | st_v[i].page;
      end
    end
  end

  assign sel_idx = onehot_to_idx(sel_v);

  assign bc = '{clear: clear, upd: done, page: page_r,
                old_valid: sel_valid, old_rank: sel_rank};

  // Pointer, fault counter, sequencer
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    faults_nxt = faults_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
          if (in_tuser) begin
            ptr_nxt    = '0;
            faults_nxt = '0;
          end
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_nxt = ST_IDLE;
          if (!hit_w) begin
            if (faults_r != FAULT_MAX) faults_nxt = faults_r + FAULT_W'(1);
            if (policy_r == POL_FIFO) begin
              ptr_nxt = (ptr_r == IDX_LAST) ? '0 : ptr_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POL_FIFO;
      ptr_r       <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      faults_r <= faults_nxt;
      if (cfg_we) policy_r <= cfg_wdata;
      if (done) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Captured request page
  always_ff @(posedge clk) begin
    if (accept) page_r <= PAGE_BITS'(in_tdata);
  end

  // Result register
  logic                  ev_valid;
  logic [OUT_EVPG_W-1:0] ev_page;

  assign ev_valid = !hit_w && sel_valid;
  assign ev_page  = ev_valid ? OUT_EVPG_W'(sel_page) : '0;

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= {3'b000, faults_nxt, ev_page, ev_valid,
                     OUT_FRAME_W'(sel_idx), hit_w};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // No request is taken while a search is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> !in_tready)
    else $error("request accepted during search");

  // At most one frame can be the oldest
  a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lru_v))
    else $error("more than one frame holds the oldest rank");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> !out_tdata[4])
    else $error("hit reported with eviction");

  // A hit leaves the fault count alone
  a_hit_faults: assert property (@(posedge clk) disable iff (!rst_n)
    (done && hit_w) |=> (faults_r == $past(faults_r)))
    else $error("fault count changed on hit");
`endif

endmodule

@@ design/prf_cell.sv @@
// One frame cell: holds page, valid and recency rank; passes search flags down the row.
module prf_cell
  import prf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  prf_bcast_t   bc,
  input  logic         wr_sel,
  input  logic         match_seen_i,
  input  logic         empty_seen_i,
  output logic         match_seen_o,
  output logic         empty_seen_o,
  output logic         first_match_o,
  output logic         first_empty_o,
  output logic         lru_o,
  output prf_cell_st_t st_o
);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 match;

  // Local compare and chain flags
  assign match         = valid_r && (page_r == bc.page);
  assign first_match_o = match && !match_seen_i;
  assign first_empty_o = !valid_r && !empty_seen_i;
  assign match_seen_o  = match_seen_i || match;
  assign empty_seen_o  = empty_seen_i || !valid_r;
  assign lru_o         = valid_r && (rank_r == RANK_MAX);
  assign st_o          = '{valid: valid_r, rank: rank_r, page: page_r};

  // Next state: clear on restart, load on write, age when younger than the touched frame or when it was empty
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (bc.clear) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (bc.upd) begin
      if (wr_sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        page_nxt  = bc.page;
      end else if (valid_r && (!bc.old_valid || (rank_r < bc.old_rank))) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // Page store needs no reset
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule
